/* src/tss_pkg.sv */
// Package for the timed step sequencer: sizes, flag bits, item kinds,
// button codes, controller states and the step pattern function.
// No dependencies; used by timed_step_sequencer_with_trip_core.
package tss_pkg;

  // Number of sequence steps and the index widths that follow from it.
  localparam int STEPS  = 7;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CNT_W  = $clog2(STEPS + 1);

  // Flag bits of the control byte.
  localparam logic [7:0] FLAG_PAUSE = 8'h20;
  localparam logic [7:0] FLAG_SCRAM = 8'h40;
  localparam logic [7:0] FLAG_RUN   = 8'h80;
  localparam logic [7:0] FLAGS_RST  = 8'h80;

  // Reset values and fixed numbers.
  localparam logic [7:0]  TPS_RST    = 8'd38;
  localparam logic [7:0]  ENTRY_RST  = 8'd1;
  localparam logic [7:0]  FULL_SCALE = 8'hFF;
  localparam logic [12:0] PULSE_HIGH = 13'd5100;
  localparam logic [12:0] PULSE_LOW  = 13'd1250;

  // Analog channels that act on the sequence.
  localparam logic [2:0] CHAN_JUMP_A  = 3'd0;
  localparam logic [2:0] CHAN_JUMP_B  = 3'd1;
  localparam logic [2:0] CHAN_TRIP_A  = 3'd3;
  localparam logic [2:0] CHAN_TRIP_B  = 3'd4;

  // Item kinds carried in the mode field.
  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_BUTTON   = 3'd1,
    MODE_CTRL_WR  = 3'd2,
    MODE_INTV_LD  = 3'd3,
    MODE_OVERRIDE = 3'd4,
    MODE_SAMPLE   = 3'd5
  } mode_t;

  // Button codes.
  typedef enum logic [1:0] {
    BTN_PAUSE = 2'd0,
    BTN_SCRAM = 2'd1,
    BTN_CLEAR = 2'd2
  } button_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_ENTER_RD,
    ST_ENTER_WR,
    ST_DONE
  } state_t;

  // Step s shows its low s+1 bits set, limited to eight bits.
  function automatic logic [7:0] pattern_of(input logic [STEP_W-1:0] s);
    logic [7:0] p;
    for (int i = 0; i < 8; i++) begin
      p[i] = (32'(s) >= i);
    end
    return p;
  endfunction

  // Flags after a button item.
  function automatic logic [7:0] button_flags(input logic [7:0] f, input logic [1:0] b);
    logic [7:0] r;
    r = f;
    unique case (b)
      BTN_PAUSE: begin
        if ((f & FLAG_SCRAM) != 8'd0) begin
          r = (f & ~(FLAG_SCRAM | FLAG_PAUSE)) | FLAG_RUN;
        end else begin
          r = f ^ FLAG_PAUSE;
        end
      end
      BTN_SCRAM: r = (f | FLAG_SCRAM | FLAG_PAUSE) & ~FLAG_RUN;
      BTN_CLEAR: r = (f & ~FLAG_SCRAM) | FLAG_RUN;
      default:   r = f;
    endcase
    return r;
  endfunction

endpackage

/* src/timed_step_sequencer_with_trip_core.sv */
// Top level of the timed step sequencer with scram trip.
// Holds the controller, the interval and timer stores and the result register.
// Depends on tss_pkg.

// Every item returns one result. Buttons, control writes, overrides,
// interval loads, samples and ticks that do not wrap the prescaler go
// from acceptance straight to the done state, which loads the result
// register. A tick that wraps the prescaler sweeps the step timers, held in a
// synchronous store with one read and one write port, one entry per cycle,
// with the read of one entry overlapping the write-back of the previous one.
// When the step advances, the sweep is followed by the read of the new
// step's interval and the timer reload. A sample that jumps the step goes
// through that read and reload as well. A new item is accepted while the
// previous result still waits in the output register, but its own result
// then waits for that register to empty, and the input is refused
// meanwhile. After reset both stores read as one in every entry; per-entry
// valid bits stand in for a clearing pass, so the block is ready at once.
module timed_step_sequencer_with_trip_core (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [1:0]  in_button,
  input  logic [7:0]  in_control_value,
  input  logic [7:0]  in_output_value,
  input  logic [2:0]  in_step_index,
  input  logic [7:0]  in_interval_value,
  input  logic [2:0]  in_analog_channel,
  input  logic [15:0] in_sample,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_control_flags,
  output logic [7:0]  out_output_pattern,
  output logic [7:0]  out_port_drive,
  output logic [12:0] out_servo_pulse,
  output logic [2:0]  out_current_step,
  output logic        out_ack
);

  localparam int SW = tss_pkg::STEP_W;
  localparam int CW = tss_pkg::CNT_W;

  // Controller and architectural state.
  tss_pkg::state_t state_r, state_nxt;
  logic [7:0]    tps_r;
  logic [7:0]    flags_r;
  logic [7:0]    pattern_r;
  logic [SW-1:0] step_r;
  logic [7:0]    presc_r;
  logic          ack_r;
  logic [SW-1:0] tgt_r;

  // Timer sweep bookkeeping.
  logic [CW-1:0] rd_idx_r;
  logic          wr_pend_r;
  logic [SW-1:0] wr_idx_r;
  logic          cur_zero_r;

  // Stores with their valid bits and registered read data.
  logic [7:0]    tmr_mem_r [tss_pkg::STEPS];
  logic [7:0]    intv_mem_r [tss_pkg::STEPS];
  logic [tss_pkg::STEPS-1:0] tmr_vld_r;
  logic [tss_pkg::STEPS-1:0] intv_vld_r;
  logic [7:0]    tmr_rd_r;
  logic          tmr_rd_vld_r;
  logic [7:0]    intv_rd_r;
  logic          intv_rd_vld_r;

  // Store port controls.
  logic          tmr_re, tmr_we, intv_re, intv_we;
  logic [SW-1:0] tmr_ra, tmr_wa, intv_ra, intv_wa;
  logic [7:0]    tmr_wd, intv_wd;

  // Result register.
  logic          out_valid_r;
  logic [7:0]    out_flags_r, out_pattern_r, out_drive_r;
  logic [12:0]   out_pulse_r;
  logic [2:0]    out_step_r;
  logic          out_ack_r;

  // Decoded item and helper values.
  logic          in_acc;
  logic [7:0]    presc_inc;
  logic          presc_wrap;
  logic          sidx_ok;
  logic [SW-1:0] sidx;
  logic          full_scale;
  logic          trip_hit, jump_a_hit, jump_b_hit;
  logic          rd_issue;
  logic [7:0]    tmr_val, tmr_dec, intv_val;
  logic          cur_zero_now;
  logic          advance;
  logic [SW-1:0] next_step;
  logic          out_free;

  assign in_ready  = (state_r == tss_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // Item decode.
  assign presc_inc  = presc_r + 8'd1;
  assign presc_wrap = (presc_inc >= tps_r);
  assign sidx_ok    = (32'(in_step_index) < tss_pkg::STEPS);
  assign sidx       = SW'(in_step_index);
  assign full_scale = (in_sample[15:8] == tss_pkg::FULL_SCALE) &&
                      ((flags_r & tss_pkg::FLAG_SCRAM) == 8'd0);
  assign trip_hit   = full_scale && ((in_analog_channel == tss_pkg::CHAN_TRIP_A) ||
                                     (in_analog_channel == tss_pkg::CHAN_TRIP_B));
  assign jump_a_hit = full_scale && (in_analog_channel == tss_pkg::CHAN_JUMP_A) &&
                      (32'(step_r) == 32'd3) && (4 < tss_pkg::STEPS);
  assign jump_b_hit = full_scale && (in_analog_channel == tss_pkg::CHAN_JUMP_B) &&
                      (32'(step_r) == 32'd5) && (6 < tss_pkg::STEPS);

  // Timer values seen during the sweep; an entry never written reads as one.
  assign rd_issue = (32'(rd_idx_r) < tss_pkg::STEPS);
  assign tmr_val  = tmr_rd_vld_r ? tmr_rd_r : tss_pkg::ENTRY_RST;
  assign tmr_dec  = (tmr_val != 8'd0) ? (tmr_val - 8'd1) : 8'd0;
  assign intv_val = intv_rd_vld_r ? intv_rd_r : tss_pkg::ENTRY_RST;

  // The current step's timer may be written back in the last sweep cycle.
  assign cur_zero_now = (wr_pend_r && (wr_idx_r == step_r)) ? (tmr_dec == 8'd0)
                                                            : cur_zero_r;
  assign advance   = ((flags_r & tss_pkg::FLAG_PAUSE) == 8'd0) && cur_zero_now;
  assign next_step = (32'(step_r) == (tss_pkg::STEPS - 1)) ? '0 : (step_r + SW'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tss_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = tss_pkg::ST_DONE;
          if ((in_mode == tss_pkg::MODE_TICK) && presc_wrap) begin
            state_nxt = tss_pkg::ST_SWEEP;
          end else if ((in_mode == tss_pkg::MODE_SAMPLE) && !trip_hit &&
                       (jump_a_hit || jump_b_hit)) begin
            state_nxt = tss_pkg::ST_ENTER_RD;
          end
        end
      end
      tss_pkg::ST_SWEEP: begin
        if (!rd_issue) begin
          state_nxt = advance ? tss_pkg::ST_ENTER_RD : tss_pkg::ST_DONE;
        end
      end
      tss_pkg::ST_ENTER_RD: state_nxt = tss_pkg::ST_ENTER_WR;
      tss_pkg::ST_ENTER_WR: state_nxt = tss_pkg::ST_DONE;
      tss_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = tss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tss_pkg::ST_IDLE;
    endcase
  end

  // Store port controls per state.
  always_comb begin
    tmr_re  = 1'b0;
    tmr_ra  = rd_idx_r[SW-1:0];
    tmr_we  = 1'b0;
    tmr_wa  = wr_idx_r;
    tmr_wd  = tmr_dec;
    intv_re = 1'b0;
    intv_ra = tgt_r;
    intv_we = 1'b0;
    intv_wa = sidx;
    intv_wd = in_interval_value;
    unique case (state_r)
      tss_pkg::ST_IDLE: begin
        if (in_acc && (in_mode == tss_pkg::MODE_INTV_LD) && sidx_ok) begin
          tmr_we  = 1'b1;
          tmr_wa  = sidx;
          tmr_wd  = in_interval_value;
          intv_we = 1'b1;
        end
      end
      tss_pkg::ST_SWEEP: begin
        tmr_re = rd_issue;
        tmr_we = wr_pend_r;
      end
      tss_pkg::ST_ENTER_RD: intv_re = 1'b1;
      tss_pkg::ST_ENTER_WR: begin
        tmr_we = 1'b1;
        tmr_wa = tgt_r;
        tmr_wd = intv_val;
      end
      tss_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  // Timer and interval stores with registered reads.
  always_ff @(posedge clk) begin
    if (tmr_we) begin
      tmr_mem_r[tmr_wa] <= tmr_wd;
    end
    if (intv_we) begin
      intv_mem_r[intv_wa] <= intv_wd;
    end
    if (tmr_re) begin
      tmr_rd_r     <= tmr_mem_r[tmr_ra];
      tmr_rd_vld_r <= tmr_vld_r[tmr_ra];
    end
    if (intv_re) begin
      intv_rd_r     <= intv_mem_r[intv_ra];
      intv_rd_vld_r <= intv_vld_r[intv_ra];
    end
  end

  // Valid bits: an entry reads as its reset value until first written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmr_vld_r  <= '0;
      intv_vld_r <= '0;
    end else begin
      if (tmr_we) begin
        tmr_vld_r[tmr_wa] <= 1'b1;
      end
      if (intv_we) begin
        intv_vld_r[intv_wa] <= 1'b1;
      end
    end
  end

  // Controller state, flags, step and prescaler.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tss_pkg::ST_IDLE;
      tps_r     <= tss_pkg::TPS_RST;
      flags_r   <= tss_pkg::FLAGS_RST;
      pattern_r <= '0;
      step_r    <= '0;
      presc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        tps_r <= cfg_wdata;
      end
      if (in_acc) begin
        unique case (in_mode)
          tss_pkg::MODE_TICK: presc_r <= presc_wrap ? 8'd0 : presc_inc;
          tss_pkg::MODE_BUTTON: flags_r <= tss_pkg::button_flags(flags_r, in_button);
          tss_pkg::MODE_CTRL_WR: flags_r <= in_control_value;
          tss_pkg::MODE_OVERRIDE: begin
            flags_r   <= in_control_value;
            pattern_r <= in_output_value;
          end
          tss_pkg::MODE_SAMPLE: begin
            if (trip_hit) begin
              flags_r <= (flags_r | tss_pkg::FLAG_SCRAM | tss_pkg::FLAG_PAUSE) &
                         ~tss_pkg::FLAG_RUN;
            end
          end
          default: ;
        endcase
      end
      // Entering a step shows its pattern.
      if (state_r == tss_pkg::ST_ENTER_WR) begin
        step_r    <= tgt_r;
        pattern_r <= tss_pkg::pattern_of(tgt_r);
      end
    end
  end

  // Sweep counters, jump target and acknowledge.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_idx_r   <= '0;
      wr_pend_r  <= 1'b0;
      cur_zero_r <= 1'b0;
      ack_r      <= (in_mode == tss_pkg::MODE_CTRL_WR);
      tgt_r      <= jump_a_hit ? SW'(4) : SW'(6);
    end else if (state_r == tss_pkg::ST_SWEEP) begin
      wr_pend_r <= rd_issue;
      wr_idx_r  <= rd_idx_r[SW-1:0];
      if (rd_issue) begin
        rd_idx_r <= rd_idx_r + CW'(1);
      end
      if (wr_pend_r && (wr_idx_r == step_r)) begin
        cur_zero_r <= (tmr_dec == 8'd0);
      end
      if (!rd_issue) begin
        tgt_r <= next_step;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == tss_pkg::ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == tss_pkg::ST_DONE) && out_free) begin
      out_flags_r   <= flags_r;
      out_pattern_r <= pattern_r;
      out_drive_r   <= ((flags_r & tss_pkg::FLAG_SCRAM) != 8'd0) ? 8'd0 : pattern_r;
      out_pulse_r   <= pattern_r[3] ? tss_pkg::PULSE_HIGH : tss_pkg::PULSE_LOW;
      out_step_r    <= 3'(step_r);
      out_ack_r     <= ack_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_control_flags  = out_flags_r;
  assign out_output_pattern = out_pattern_r;
  assign out_port_drive     = out_drive_r;
  assign out_servo_pulse    = out_pulse_r;
  assign out_current_step   = out_step_r;
  assign out_ack            = out_ack_r;

endmodule
